// ===== rtl/cttb_pkg.sv =====
// ----------------------------------------------------------------------------
// cttb_pkg
// shared types, codes and helpers for the code page to unicode table
// ----------------------------------------------------------------------------
package cttb_pkg;

  localparam int TABLE_DEPTH_DEF = 128;

  // operation codes
  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_LOOKUP = 2'd2;
  localparam logic [1:0] OP_READ   = 2'd3;

  // code page selects
  localparam logic [1:0] PG_CP1251 = 2'd0;
  localparam logic [1:0] PG_ISO    = 2'd1;
  localparam logic [1:0] PG_KOI8   = 2'd2;
  localparam logic [1:0] PG_BAD    = 2'd3;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_FULL    = 3'd1;
  localparam logic [2:0] ST_EMPTY   = 3'd2;
  localparam logic [2:0] ST_RANGE   = 3'd3;
  localparam logic [2:0] ST_BADPAGE = 3'd4;

  typedef struct packed {
    logic [1:0]  op;
    logic [1:0]  code_page;
    logic [7:0]  key_byte;
    logic [6:0]  entry_index;
    logic [15:0] new_code;
    logic [7:0]  new_koi8;
    logic [7:0]  new_iso;
    logic [7:0]  new_cp1251;
  } in_t;

  typedef struct packed {
    logic [15:0] code_out;
    logic        matched;
    logic [7:0]  koi8_out;
    logic [7:0]  iso_out;
    logic [7:0]  cp1251_out;
    logic [2:0]  status;
  } out_t;

  typedef struct packed {
    logic [15:0] code;
    logic [7:0]  koi8;
    logic [7:0]  iso;
    logic [7:0]  cp1251;
  } entry_t;

  // control from the sequencer to the cell row
  typedef struct packed {
    logic shift;
    logic wr;
  } ctl_t;

  function automatic logic [7:0] page_byte(entry_t e, logic [1:0] page);
    logic [7:0] b;
    unique case (page)
      PG_CP1251: b = e.cp1251;
      PG_ISO:    b = e.iso;
      default:   b = e.koi8;
    endcase
    return b;
  endfunction

endpackage

// ===== rtl/codepage_to_unicode_table.sv =====
// ----------------------------------------------------------------------------
// codepage_to_unicode_table
// cyrillic code page to unicode table: clear, append, lookup and read requests
// ----------------------------------------------------------------------------
//
//   channel   handshake               payload   direction
//   in_       in_valid / in_ready     in_t      request in
//   out_      out_valid / out_ready   out_t     result out
//
// clear and append: the result is registered in the sequencer, then moves
// to the output register once out_ is free; the next request can be taken
// after that. lookup and read (past the range checks) first make one full
// turn of the cell row past the single comparator at its head.
// requests are taken one at a time, only in idle; a finished result waiting
// at out_ does not block the next request, but a second result waits in
// the sequencer until out_ drains.
// reset is synchronous, active low; it clears the fill count and control,
// the cells themselves are not reset.
//
module codepage_to_unicode_table
  import cttb_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  // row of slots, cell i takes cell i+1 on a shift, the last wraps to cell 0
  entry_t           cell_q [TABLE_DEPTH];
  entry_t           wr_entry;
  ctl_t             ctl;
  logic [IDX_W-1:0] wr_slot;

  // append data comes straight from the request being taken
  assign wr_entry.code   = in_data.new_code;
  assign wr_entry.koi8   = in_data.new_koi8;
  assign wr_entry.iso    = in_data.new_iso;
  assign wr_entry.cp1251 = in_data.new_cp1251;

  // sequencer: fill count, scan step, compare at the head, result register
  cttb_seq #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .head     (cell_q[0]),
    .ctl      (ctl),
    .wr_slot  (wr_slot)
  );

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    // append lands in the slot at the fill count
    logic wr_en;
    assign wr_en = ctl.wr && (wr_slot == IDX_W'(i));

    cttb_cell u_cell (
      .clk     (clk),
      .shift_en(ctl.shift),
      .wr_en   (wr_en),
      .wr_data (wr_entry),
      .nbr_data(cell_q[(i + 1) % TABLE_DEPTH]),
      .data_r  (cell_q[i])
    );
  end

endmodule

// ===== rtl/cttb_cell.sv =====
// ----------------------------------------------------------------------------
// cttb_cell
// one table slot of the rotating cell row
// ----------------------------------------------------------------------------
module cttb_cell
  import cttb_pkg::*;
(
  input  logic   clk,
  input  logic   shift_en,
  input  logic   wr_en,
  input  entry_t wr_data,
  input  entry_t nbr_data,
  output entry_t data_r
);

  entry_t data_nxt;

  // write and shift never coincide
  always_comb begin
    data_nxt = data_r;
    if (wr_en) begin
      data_nxt = wr_data;
    end else if (shift_en) begin
      data_nxt = nbr_data;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

// ===== rtl/cttb_seq.sv =====
// ----------------------------------------------------------------------------
// cttb_seq
// request sequencer: fill count, scan over the rotating row, result register
// ----------------------------------------------------------------------------
module cttb_seq
  import cttb_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1,
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1)
)
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  in_t              in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output out_t             out_data,
  input  entry_t           head,
  output ctl_t             ctl,
  output logic [IDX_W-1:0] wr_slot
);

  localparam int CW = (CNT_W > 7) ? CNT_W : 7;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [IDX_W-1:0] step_r, step_nxt;
  logic             hit_r, hit_nxt;
  logic [1:0]       op_r, op_nxt;
  logic [1:0]       page_r, page_nxt;
  logic [7:0]       key_r, key_nxt;
  logic [6:0]       idx_r, idx_nxt;
  out_t             res_r, res_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_t             out_data_r, out_data_nxt;
  logic             accept;
  logic             in_range;

  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign wr_slot   = count_r[IDX_W-1:0];
  assign in_range  = CW'(step_r) < CW'(count_r);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    step_nxt      = step_r;
    hit_nxt       = hit_r;
    op_nxt        = op_r;
    page_nxt      = page_r;
    key_nxt       = key_r;
    idx_nxt       = idx_r;
    res_nxt       = res_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    ctl           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          op_nxt   = in_data.op;
          page_nxt = in_data.code_page;
          key_nxt  = in_data.key_byte;
          idx_nxt  = in_data.entry_index;
          hit_nxt  = 1'b0;
          step_nxt = '0;
          res_nxt  = '0;
          state_nxt = S_FIN;
          unique case (in_data.op)
            OP_CLEAR: begin
              count_nxt = '0;
            end
            OP_APPEND: begin
              if (count_r == CNT_W'(TABLE_DEPTH)) begin
                res_nxt.status = ST_FULL;
              end else begin
                ctl.wr    = 1'b1;
                count_nxt = count_r + CNT_W'(1);
              end
            end
            OP_LOOKUP: begin
              res_nxt.code_out = {8'd0, in_data.key_byte};
              priority if (in_data.code_page == PG_BAD) begin
                res_nxt.status = ST_BADPAGE;
              end else if (count_r == '0) begin
                res_nxt.status = ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              if (CW'(in_data.entry_index) >= CW'(count_r)) begin
                res_nxt.status = ST_RANGE;
              end else begin
                state_nxt = S_SCAN;
              end
            end
          endcase
        end
      end
      S_SCAN: begin
        // head holds slot step_r; one full turn brings the row home
        ctl.shift = 1'b1;
        step_nxt  = step_r + IDX_W'(1);
        if (in_range && !hit_r) begin
          if (op_r == OP_LOOKUP) begin
            if (page_byte(head, page_r) == key_r) begin
              hit_nxt          = 1'b1;
              res_nxt.code_out = head.code;
              res_nxt.matched  = 1'b1;
            end
          end else if (CW'(step_r) == CW'(idx_r)) begin
            hit_nxt            = 1'b1;
            res_nxt.code_out   = head.code;
            res_nxt.koi8_out   = head.koi8;
            res_nxt.iso_out    = head.iso;
            res_nxt.cp1251_out = head.cp1251;
          end
        end
        if (step_r == IDX_W'(TABLE_DEPTH - 1)) begin
          step_nxt  = '0;
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_data_nxt  = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      step_r      <= step_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    page_r     <= page_nxt;
    key_r      <= key_nxt;
    idx_r      <= idx_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

// ===== rtl/cttb_checker.sv =====
// ----------------------------------------------------------------------------
// cttb_checker
// port-level checks for the code page to unicode table, bound to the top
// ----------------------------------------------------------------------------
module cttb_checker
  import cttb_pkg::*;
(
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // a stalled result stays up
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // one request at a time: taking one closes the input for the next cycle
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");

  // a hit only comes with ok status
  a_hit_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.matched |-> out_data.status == ST_OK)
    else $error("hit with error status");

  // an error result carries no entry bytes
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != ST_OK) |->
      (out_data.koi8_out == 8'd0) && (out_data.iso_out == 8'd0) &&
      (out_data.cp1251_out == 8'd0) && !out_data.matched)
    else $error("error result carries entry data");

endmodule

bind codepage_to_unicode_table cttb_checker u_cttb_checker (
  .clk      (clk),
  .rst_n    (rst_n),
  .in_valid (in_valid),
  .in_ready (in_ready),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .out_data (out_data)
);

// ===== dv/codepage_to_unicode_table_test.sv =====
// ----------------------------------------------------------------------------
// codepage_to_unicode_table_test
// self-checking bench for the code page to unicode table: a short table of
// directed requests, then random clear / append / lookup / read episodes,
// every result checked against a shadow copy of the table
// ----------------------------------------------------------------------------
module codepage_to_unicode_table_test;
  import cttb_pkg::*;

  localparam int TABLE_DEPTH  = TABLE_DEPTH_DEF;
  localparam int RANDOM_ITEMS = 600;
  // slowest request is a full-table lookup, one full turn of the row, plus the
  // longest receiver stall and sender gap; taken several times over
  localparam int CYCLE_LIMIT  = 600000;

  // directed row: the request, and the typed-in result where one is given
  typedef struct {
    in_t  req;
    bit   typed;
    out_t res;
  } directed_row_t;

  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_ready;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // shadow of the table contents and fill count
  entry_t      shadow_entries [TABLE_DEPTH];
  int unsigned shadow_fill = 0;

  out_t pending_results [$];
  directed_row_t directed_requests [$];

  // bookkeeping for the summary
  int n_errors = 0, n_checked = 0, req_count = 0, cycle_count = 0;
  int n_clear = 0, n_append = 0, n_full = 0, n_lookup = 0, n_hit = 0;
  int n_badpage = 0, n_read = 0, n_range = 0;

  // sender burst state
  int burst_left = 0;

  codepage_to_unicode_table #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run watchdog, also the cycle count for the summary
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d results still pending", cycle_count,
             pending_results.size());
    $display("Simulation FAILED");
    $finish;
  end

  task automatic report_error(input string msg);
    if (n_errors < 40) $display("ERROR @%0d: %s", cycle_count, msg);
    n_errors++;
  endtask

  // byte of an entry as seen through one code page
  function automatic logic [7:0] byte_in_page(input entry_t e, input logic [1:0] page);
    case (page)
      PG_CP1251: return e.cp1251;
      PG_ISO:    return e.iso;
      default:   return e.koi8;
    endcase
  endfunction

  // expected result of one request, updating the shadow table as it goes
  function automatic out_t predict_table_result(input in_t req);
    out_t   r;
    entry_t e;
    r = '0;
    case (req.op)
      OP_CLEAR: begin
        shadow_fill = 0;
        n_clear++;
      end
      OP_APPEND: begin
        n_append++;
        if (shadow_fill >= TABLE_DEPTH) begin
          // table full: nothing written, count held
          r.status = ST_FULL;
          n_full++;
        end else begin
          e.code   = req.new_code;
          e.koi8   = req.new_koi8;
          e.iso    = req.new_iso;
          e.cp1251 = req.new_cp1251;
          shadow_entries[shadow_fill] = e;
          shadow_fill++;
        end
      end
      OP_LOOKUP: begin
        n_lookup++;
        r.code_out = {8'h00, req.key_byte};
        if (req.code_page == PG_BAD) begin
          // bad page wins over the empty check
          r.status = ST_BADPAGE;
          n_badpage++;
        end else if (shadow_fill == 0) begin
          r.status = ST_EMPTY;
        end else begin
          // first matching slot wins
          for (int i = 0; i < shadow_fill; i++) begin
            if (!r.matched && byte_in_page(shadow_entries[i], req.code_page) == req.key_byte)
            begin
              r.code_out = shadow_entries[i].code;
              r.matched  = 1'b1;
            end
          end
          if (r.matched) n_hit++;
        end
      end
      default: begin
        n_read++;
        if (req.entry_index >= shadow_fill) begin
          r.status = ST_RANGE;
          n_range++;
        end else begin
          e = shadow_entries[req.entry_index];
          r.code_out   = e.code;
          r.koi8_out   = e.koi8;
          r.iso_out    = e.iso;
          r.cp1251_out = e.cp1251;
        end
      end
    endcase
    return r;
  endfunction

  function automatic in_t mk_req(input logic [1:0] op, input logic [1:0] page,
                                 input logic [7:0] key, input logic [6:0] idx,
                                 input logic [15:0] code, input logic [7:0] k8,
                                 input logic [7:0] iso, input logic [7:0] cp);
    in_t r;
    r.op          = op;
    r.code_page   = page;
    r.key_byte    = key;
    r.entry_index = idx;
    r.new_code    = code;
    r.new_koi8    = k8;
    r.new_iso     = iso;
    r.new_cp1251  = cp;
    return r;
  endfunction

  // typed-in results never carry entry bytes
  function automatic out_t mk_res(input logic [15:0] code, input logic matched,
                                  input logic [2:0] status);
    out_t r;
    r          = '0;
    r.code_out = code;
    r.matched  = matched;
    r.status   = status;
    return r;
  endfunction

  // fully random request, fields overwritten by the caller as needed
  function automatic in_t random_request();
    logic [$bits(in_t)-1:0] raw;
    raw = $bits(in_t)'({$urandom, $urandom});
    return in_t'(raw);
  endfunction

  // byte biased toward a small cluster so that appends collide and the
  // first-match rule gets exercised, with the extremes mixed in
  function automatic logic [7:0] random_byte();
    case ($urandom_range(0, 3))
      0:       return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
      1:       return 8'hC0 + 8'($urandom_range(0, 7));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // send one request, honoring the burst / gap pattern, and record its result
  task automatic send_request(input in_t req, input bit typed, input out_t typed_res);
    int   gap;
    out_t want;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 32);
      // some bursts follow straight on, others after a gap
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 16);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    // accepted at this edge
    want = predict_table_result(req);
    if (typed) want = typed_res;
    pending_results.push_back(want);
    req_count++;
  endtask

  // hold off the sender until every pending result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  // receiver: stretches of always-ready, coin-flip, hard stall and sparse ready
  always @(posedge clk) begin
    static int stall_mode = 0;
    static int stall_left = 0;
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = (stall_mode == 2) ? $urandom_range(1, 24) : $urandom_range(4, 40);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      0:       out_ready <= 1'b1;
      1:       out_ready <= ($urandom_range(0, 1) != 0);
      2:       out_ready <= 1'b0;
      default: out_ready <= (stall_left % 4 == 0);
    endcase
  end

  task automatic check_field(input string name, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want)
      report_error($sformatf("result %0d: %s got %h expected %h", n_checked, name, got, want));
  endtask

  // result checker, oldest expectation first
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_error($sformatf("result %0d arrived with nothing pending", n_checked));
      end else begin
        want = pending_results.pop_front();
        check_field("code_out", out_data.code_out, want.code_out);
        check_field("matched", 16'(out_data.matched), 16'(want.matched));
        check_field("koi8_out", 16'(out_data.koi8_out), 16'(want.koi8_out));
        check_field("iso_out", 16'(out_data.iso_out), 16'(want.iso_out));
        check_field("cp1251_out", 16'(out_data.cp1251_out), 16'(want.cp1251_out));
        check_field("status", 16'(out_data.status), 16'(want.status));
      end
      n_checked++;
    end
  end

  // stimulus
  initial begin
    in_t req;
    int  ep;
    int  n_app;
    int  n_qry;
    logic [1:0] page;

    // directed table: op, page, key, index, code, koi8, iso, cp1251
    // empty table: lookup, bad page, reads at both index extremes
    directed_requests.push_back('{mk_req(OP_LOOKUP, PG_CP1251, 8'hFF, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b1, mk_res(16'h00FF, 1'b0, ST_EMPTY)});
    directed_requests.push_back('{mk_req(OP_LOOKUP, PG_BAD, 8'h00, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b1, mk_res(16'h0000, 1'b0, ST_BADPAGE)});
    directed_requests.push_back('{mk_req(OP_READ, PG_CP1251, 8'h00, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b1, mk_res(16'h0, 1'b0, ST_RANGE)});
    directed_requests.push_back('{mk_req(OP_READ, PG_CP1251, 8'h00, 7'd127, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b1, mk_res(16'h0, 1'b0, ST_RANGE)});
    // appends with extreme fields, two entries sharing cp1251 byte c0
    directed_requests.push_back('{mk_req(OP_APPEND, PG_CP1251, 8'h00, 7'd0, 16'hFFFF, 8'hFF,
      8'h00, 8'hAA), 1'b1, mk_res(16'h0, 1'b0, ST_OK)});
    directed_requests.push_back('{mk_req(OP_APPEND, PG_CP1251, 8'h00, 7'd0, 16'h0000, 8'h00,
      8'hFF, 8'h55), 1'b1, mk_res(16'h0, 1'b0, ST_OK)});
    directed_requests.push_back('{mk_req(OP_APPEND, PG_CP1251, 8'h00, 7'd0, 16'h0410, 8'hE1,
      8'hB0, 8'hC0), 1'b1, mk_res(16'h0, 1'b0, ST_OK)});
    directed_requests.push_back('{mk_req(OP_APPEND, PG_CP1251, 8'h00, 7'd0, 16'h1234, 8'hC0,
      8'hC0, 8'hC0), 1'b1, mk_res(16'h0, 1'b0, ST_OK)});
    // lookups on every page, first match, miss
    directed_requests.push_back('{mk_req(OP_LOOKUP, PG_CP1251, 8'hC0, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b0, '0});
    directed_requests.push_back('{mk_req(OP_LOOKUP, PG_ISO, 8'hFF, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b0, '0});
    directed_requests.push_back('{mk_req(OP_LOOKUP, PG_KOI8, 8'hFF, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b0, '0});
    directed_requests.push_back('{mk_req(OP_LOOKUP, PG_KOI8, 8'hC0, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b0, '0});
    directed_requests.push_back('{mk_req(OP_LOOKUP, PG_CP1251, 8'h7F, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b0, '0});
    // bad page on a loaded table
    directed_requests.push_back('{mk_req(OP_LOOKUP, PG_BAD, 8'h80, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b1, mk_res(16'h0080, 1'b0, ST_BADPAGE)});
    // reads at first, last and one past the last slot
    directed_requests.push_back('{mk_req(OP_READ, PG_CP1251, 8'h00, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b0, '0});
    directed_requests.push_back('{mk_req(OP_READ, PG_CP1251, 8'h00, 7'd3, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b0, '0});
    directed_requests.push_back('{mk_req(OP_READ, PG_CP1251, 8'h00, 7'd4, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b1, mk_res(16'h0, 1'b0, ST_RANGE)});
    // clear, then the table behaves as empty again
    directed_requests.push_back('{mk_req(OP_CLEAR, PG_CP1251, 8'h00, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b1, mk_res(16'h0, 1'b0, ST_OK)});
    directed_requests.push_back('{mk_req(OP_LOOKUP, PG_ISO, 8'h00, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b1, mk_res(16'h0000, 1'b0, ST_EMPTY)});
    directed_requests.push_back('{mk_req(OP_READ, PG_CP1251, 8'h00, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b1, mk_res(16'h0, 1'b0, ST_RANGE)});
    directed_requests.push_back('{mk_req(OP_APPEND, PG_CP1251, 8'h00, 7'd0, 16'h7FFF, 8'h80,
      8'h01, 8'hFE), 1'b1, mk_res(16'h0, 1'b0, ST_OK)});
    directed_requests.push_back('{mk_req(OP_READ, PG_CP1251, 8'h00, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b0, '0});
    directed_requests.push_back('{mk_req(OP_LOOKUP, PG_CP1251, 8'hFE, 7'd0, 16'h0, 8'h0, 8'h0,
      8'h0), 1'b0, '0});

    // reset held at the start, once
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_requests[i])
      send_request(directed_requests[i].req, directed_requests[i].typed,
                   directed_requests[i].res);

    // random episodes: mostly fill-then-query sequences with random content,
    // the rest noise requests with every field random
    ep = 0;
    while (req_count < directed_requests.size() + RANDOM_ITEMS) begin
      // sender pauses for a full drain every so often
      if (ep % 7 == 6) drain_results();
      if (ep == 2 || ep == 11 || $urandom_range(0, 9) < 7) begin
        if (ep == 2 || $urandom_range(0, 2) == 0) begin
          req    = random_request();
          req.op = OP_CLEAR;
          send_request(req, 1'b0, '0);
        end
        // two episodes run the table past full
        if (ep == 2 || ep == 11)
          n_app = TABLE_DEPTH - shadow_fill + $urandom_range(1, 3);
        else
          n_app = $urandom_range(1, 10);
        repeat (n_app) begin
          req            = random_request();
          req.op         = OP_APPEND;
          req.new_koi8   = random_byte();
          req.new_iso    = random_byte();
          req.new_cp1251 = random_byte();
          send_request(req, 1'b0, '0);
        end
        n_qry = $urandom_range(4, 16);
        repeat (n_qry) begin
          req = random_request();
          if ($urandom_range(0, 2) != 0) begin
            req.op = OP_LOOKUP;
            page   = ($urandom_range(0, 9) == 0) ? PG_BAD : 2'($urandom_range(0, 2));
            req.code_page = page;
            // mostly keys taken from stored entries so that lookups hit
            if (shadow_fill != 0 && page != PG_BAD && $urandom_range(0, 3) != 0)
              req.key_byte = byte_in_page(shadow_entries[$urandom_range(0, shadow_fill - 1)],
                                          page);
            else
              req.key_byte = random_byte();
          end else begin
            req.op = OP_READ;
            if (shadow_fill != 0 && $urandom_range(0, 4) != 0)
              req.entry_index = 7'($urandom_range(0, shadow_fill - 1));
          end
          send_request(req, 1'b0, '0);
        end
      end else begin
        repeat ($urandom_range(3, 10)) send_request(random_request(), 1'b0, '0);
      end
      ep++;
    end

    // drain, then give a stray result time to show up
    drain_results();
    repeat (TABLE_DEPTH + 8) @(posedge clk);

    $display("covered %0d requests: %0d clear, %0d append (%0d on a full table), %0d lookup",
             req_count, n_clear, n_append, n_full, n_lookup);
    $display("  (%0d hits, %0d bad page), %0d read (%0d out of range); %0d results in %0d cycles",
             n_hit, n_badpage, n_read, n_range, n_checked, cycle_count);
    if (n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", n_errors);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
